>>> hw/rtl/tup_pkg.sv
// ----------------------------------------------------------------------------
// Text to unsigned parser package
// Shared types, character codes and helper functions for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tup_pkg;

    // Default sizing
    localparam int TUP_MAX_LEN    = 1024;
    localparam int TUP_VALUE_BITS = 32;

    // Radix register
    localparam int              BASE_W     = 6;
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] UPPER_BIAS = CH_UPPER_A - 8'd10;
    localparam logic [7:0] LOWER_BIAS = CH_LOWER_A - 8'd10;
    localparam logic [7:0] NO_DIGIT   = 8'hFF;

    // Parse phase
    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    // Digit status
    typedef enum logic [1:0] {
        ST_NONE,
        ST_DIGITS,
        ST_OVF
    } t_status;

    // Control part of the parse state
    typedef struct packed {
        t_phase             phase;
        logic               negative;
        t_status            status;
        logic [BASE_W-1:0]  active_base;
    } t_ctrl;

    localparam t_ctrl CTRL_RESET = '{
        phase:       PH_SPACE,
        negative:    1'b0,
        status:      ST_NONE,
        active_base: BASE_AUTO
    };

    // Whitespace: space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Digit value of a character, NO_DIGIT for anything else
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        v = NO_DIGIT;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            v = c - CH_ZERO;
        end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
            v = c - UPPER_BIAS;
        end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) begin
            v = c - LOWER_BIAS;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tup_if.sv
// ----------------------------------------------------------------------------
// Text to unsigned parser channels
// Valid/ready channels for radix writes, characters and results.
// ----------------------------------------------------------------------------
`default_nettype none

// Radix register write channel
interface tup_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tup_pkg::BASE_W-1:0] number_base;

    modport source (output valid, output number_base, input ready);
    modport sink   (input valid, input number_base, output ready);
endinterface

// Character channel
interface tup_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

// Result channel
interface tup_out_if #(
    parameter int VALUE_BITS = tup_pkg::TUP_VALUE_BITS,
    parameter int END_W      = $clog2(tup_pkg::TUP_MAX_LEN + 1)
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  overflowed;
    logic                  digits_found;
    logic [END_W-1:0]      end_offset;

    modport source (output valid, output value, output overflowed,
                    output digits_found, output end_offset, input ready);
    modport sink   (input valid, input value, input overflowed,
                    input digits_found, input end_offset, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tup_step.sv
// ----------------------------------------------------------------------------
// Text to unsigned parser step
// Next parse state and result for one character, combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module tup_step #(
    parameter int VALUE_BITS = tup_pkg::TUP_VALUE_BITS,
    parameter int MAX_LEN    = tup_pkg::TUP_MAX_LEN,
    parameter int POS_W      = $clog2(tup_pkg::TUP_MAX_LEN + 1)
) (
    input  wire logic [7:0]                 i_ch,
    input  wire logic                       i_last,
    input  wire logic [tup_pkg::BASE_W-1:0] i_base,
    input  wire tup_pkg::t_ctrl             i_ctrl,
    input  wire logic [VALUE_BITS-1:0]      i_acc,
    input  wire logic [POS_W-1:0]           i_pos,
    input  wire logic [POS_W-1:0]           i_stop,
    output tup_pkg::t_ctrl                  o_ctrl,
    output logic [VALUE_BITS-1:0]           o_acc,
    output logic [POS_W-1:0]                o_pos,
    output logic [POS_W-1:0]                o_stop,
    output logic [VALUE_BITS-1:0]           o_value,
    output logic                            o_overflowed,
    output logic                            o_digits_found,
    output logic [POS_W-1:0]                o_end_offset
);

    localparam int BW   = tup_pkg::BASE_W;
    localparam int PW   = VALUE_BITS + BW;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);
    localparam logic [VALUE_BITS-1:0] OVF_VALUE = {1'b0, {(VALUE_BITS-1){1'b1}}};

    tup_pkg::t_ctrl          mid_ctrl;
    logic [VALUE_BITS-1:0]   mid_acc;
    logic                    take_en;
    logic                    zero_start;
    logic [BW-1:0]           first_base;
    logic [BW-1:0]           zero_base;
    logic [BW-1:0]           digit_base;
    logic [7:0]              digit;
    logic                    digit_stop;
    logic [PW-1:0]           mac;
    logic                    mac_ovf;
    tup_pkg::t_ctrl          dig_ctrl;
    logic [VALUE_BITS-1:0]   dig_acc;
    logic [POS_W-1:0]        dig_stop;
    logic [POS_W-1:0]        pos_inc;

    assign first_base = (i_base == tup_pkg::BASE_AUTO) ? tup_pkg::BASE_DEC : i_base;
    assign zero_base  = (i_base == tup_pkg::BASE_AUTO) ? tup_pkg::BASE_OCT
                                                       : tup_pkg::BASE_HEX;
    assign zero_start = (i_ch == tup_pkg::CH_ZERO) &&
                        ((i_base == tup_pkg::BASE_AUTO) || (i_base == tup_pkg::BASE_HEX));

    // Sign, prefix and phase handling ahead of the digit stage
    always_comb begin
        mid_ctrl = i_ctrl;
        mid_acc  = i_acc;
        take_en  = 1'b0;
        unique case (i_ctrl.phase)
            tup_pkg::PH_SPACE, tup_pkg::PH_SIGNED: begin
                if ((i_ctrl.phase == tup_pkg::PH_SPACE) && tup_pkg::is_space(i_ch)) begin
                    mid_ctrl = i_ctrl;
                end else if ((i_ctrl.phase == tup_pkg::PH_SPACE) &&
                             (i_ch == tup_pkg::CH_MINUS)) begin
                    mid_ctrl.negative = 1'b1;
                    mid_ctrl.phase    = tup_pkg::PH_SIGNED;
                end else if ((i_ctrl.phase == tup_pkg::PH_SPACE) &&
                             (i_ch == tup_pkg::CH_PLUS)) begin
                    mid_ctrl.phase = tup_pkg::PH_SIGNED;
                end else if (zero_start) begin
                    mid_ctrl.phase = tup_pkg::PH_ZERO;
                end else begin
                    mid_ctrl.active_base = first_base;
                    mid_ctrl.phase       = tup_pkg::PH_DIGITS;
                    take_en              = 1'b1;
                end
            end
            tup_pkg::PH_ZERO: begin
                if ((i_ch == tup_pkg::CH_LOWER_X) || (i_ch == tup_pkg::CH_UPPER_X)) begin
                    mid_ctrl.active_base = tup_pkg::BASE_HEX;
                    mid_ctrl.phase       = tup_pkg::PH_DIGITS;
                end else begin
                    // the pending zero counts as a digit, then this char is taken
                    mid_ctrl.active_base = zero_base;
                    mid_ctrl.phase       = tup_pkg::PH_DIGITS;
                    mid_ctrl.status      = tup_pkg::ST_DIGITS;
                    mid_acc              = '0;
                    take_en              = 1'b1;
                end
            end
            tup_pkg::PH_DIGITS: begin
                take_en = 1'b1;
            end
            default: begin
                mid_ctrl = i_ctrl;
            end
        endcase
    end

    // Digit stage: multiply-add by the radix with overflow detect
    assign digit_base = (mid_ctrl.active_base == tup_pkg::BASE_AUTO) ? tup_pkg::BASE_DEC
                                                                     : mid_ctrl.active_base;
    assign digit      = tup_pkg::digit_value(i_ch);
    assign digit_stop = digit >= {2'b00, digit_base};
    assign mac        = ({{BW{1'b0}}, mid_acc} * PW'(digit_base)) + PW'(digit);
    assign mac_ovf    = |mac[PW-1:VALUE_BITS];

    always_comb begin
        dig_ctrl = mid_ctrl;
        dig_acc  = mid_acc;
        dig_stop = i_stop;
        if (take_en) begin
            if (digit_stop) begin
                dig_ctrl.phase = tup_pkg::PH_DONE;
                dig_stop       = i_pos;
            end else if ((mid_ctrl.status == tup_pkg::ST_OVF) || mac_ovf) begin
                dig_ctrl.status = tup_pkg::ST_OVF;
            end else begin
                dig_ctrl.status = tup_pkg::ST_DIGITS;
                dig_acc         = mac[VALUE_BITS-1:0];
            end
        end
    end

    // Position count, end of string and result
    assign pos_inc = (i_pos < POS_MAX) ? i_pos + 1'b1 : POS_MAX;

    always_comb begin
        o_ctrl         = dig_ctrl;
        o_acc          = dig_acc;
        o_pos          = pos_inc;
        o_stop         = dig_stop;
        o_value        = '0;
        o_overflowed   = 1'b0;
        o_digits_found = 1'b0;
        o_end_offset   = '0;
        if (i_last) begin
            // a lone leading zero at the end is a digit of value zero
            if (dig_ctrl.phase == tup_pkg::PH_ZERO) begin
                o_ctrl.phase  = tup_pkg::PH_DIGITS;
                o_ctrl.status = tup_pkg::ST_DIGITS;
                o_acc         = '0;
            end
            o_end_offset = (o_ctrl.phase == tup_pkg::PH_DONE) ? dig_stop : pos_inc;
            if (o_ctrl.status == tup_pkg::ST_NONE) begin
                o_end_offset = '0;
            end
            if (o_ctrl.status == tup_pkg::ST_OVF) begin
                o_value = OVF_VALUE;
            end else if (o_ctrl.negative) begin
                o_value = '0 - o_acc;
            end else begin
                o_value = o_acc;
            end
            o_overflowed   = (o_ctrl.status == tup_pkg::ST_OVF);
            o_digits_found = (o_ctrl.status != tup_pkg::ST_NONE);
            // parse state returns to its reset values
            o_ctrl = tup_pkg::CTRL_RESET;
            o_acc  = '0;
            o_pos  = '0;
            o_stop = '0;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/text_to_unsigned_parser_unit.sv
// Throughput: one character per cycle; a last character waits while a result beat
//   is still untaken. The multiply-add by the radix and the overflow check sit in a
//   single stage between the input and result registers, which a last character passes
//   in turn. A string gives one result beat, on its last character.
// Reset: clears the parse state and both stages; the radix returns to 10.
// ----------------------------------------------------------------------------
// Text to unsigned parser unit
// Streams characters into a strtoul style conversion with overflow detect.
// ----------------------------------------------------------------------------
`default_nettype none

module text_to_unsigned_parser_unit #(
    parameter int MAX_LEN    = tup_pkg::TUP_MAX_LEN,
    parameter int VALUE_BITS = tup_pkg::TUP_VALUE_BITS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tup_cfg_if.sink      i_cfg,
    tup_in_if.sink       i_char,
    tup_out_if.source    o_result
);

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam int BW    = tup_pkg::BASE_W;

    // Radix register
    logic [BW-1:0] r_base;

    // Input stage
    logic          r_in_valid;
    logic [7:0]    r_ch;
    logic          r_last;
    logic          stage_fire;

    // Parse state
    tup_pkg::t_ctrl         r_ctrl;
    logic [VALUE_BITS-1:0]  r_acc;
    logic [POS_W-1:0]       r_pos;
    logic [POS_W-1:0]       r_stop;
    tup_pkg::t_ctrl         n_ctrl;
    logic [VALUE_BITS-1:0]  n_acc;
    logic [POS_W-1:0]       n_pos;
    logic [POS_W-1:0]       n_stop;

    // Result stage
    logic                   r_out_valid;
    logic [VALUE_BITS-1:0]  r_value;
    logic                   r_overflowed;
    logic                   r_digits_found;
    logic [POS_W-1:0]       r_end_offset;
    logic [VALUE_BITS-1:0]  n_value;
    logic                   n_overflowed;
    logic                   n_digits_found;
    logic [POS_W-1:0]       n_end_offset;

    // Handshakes: a non-last beat never waits on the result side
    assign stage_fire   = r_in_valid && (!r_last || !r_out_valid || o_result.ready);
    assign i_char.ready = !r_in_valid || stage_fire;
    assign i_cfg.ready  = 1'b1;

    // Radix register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= tup_pkg::BASE_RESET;
        end else if (i_cfg.valid) begin
            r_base <= i_cfg.number_base;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_ch   <= i_char.ch;
            r_last <= i_char.last;
        end
    end

    // Per-character step
    tup_step #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_LEN    (MAX_LEN),
        .POS_W      (POS_W)
    ) u_step (
        .i_ch           (r_ch),
        .i_last         (r_last),
        .i_base         (r_base),
        .i_ctrl         (r_ctrl),
        .i_acc          (r_acc),
        .i_pos          (r_pos),
        .i_stop         (r_stop),
        .o_ctrl         (n_ctrl),
        .o_acc          (n_acc),
        .o_pos          (n_pos),
        .o_stop         (n_stop),
        .o_value        (n_value),
        .o_overflowed   (n_overflowed),
        .o_digits_found (n_digits_found),
        .o_end_offset   (n_end_offset)
    );

    // Parse state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= tup_pkg::CTRL_RESET;
            r_acc  <= '0;
            r_pos  <= '0;
            r_stop <= '0;
        end else if (stage_fire) begin
            r_ctrl <= n_ctrl;
            r_acc  <= n_acc;
            r_pos  <= n_pos;
            r_stop <= n_stop;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_fire && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_fire && r_last) begin
            r_value        <= n_value;
            r_overflowed   <= n_overflowed;
            r_digits_found <= n_digits_found;
            r_end_offset   <= n_end_offset;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.value        = r_value;
    assign o_result.overflowed   = r_overflowed;
    assign o_result.digits_found = r_digits_found;
    assign o_result.end_offset   = r_end_offset;

endmodule

`default_nettype wire

>>> tb/tb_text_to_unsigned_parser_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text to unsigned parser unit testbench
// Streams strings through the parser under a range of radix settings, with
// random gaps on the character side and random stalls on the result side.
// Every result beat is checked field by field against a conversion model
// kept in the bench.
// ----------------------------------------------------------------------------

module tb_text_to_unsigned_parser_unit;

    localparam int          END_W         = $clog2(tup_pkg::TUP_MAX_LEN + 1);
    localparam logic [31:0] VALUE_MAX     = 32'hFFFF_FFFF;
    localparam logic [31:0] OVF_CLAMP     = VALUE_MAX >> 1;
    localparam int unsigned NOT_ALNUM     = 255;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned RANDOM_CHARS  = 80;
    localparam int unsigned REPORT_LIMIT  = 10;

    // Radix settings beyond those the package names
    localparam logic [tup_pkg::BASE_W-1:0] BASE_UNARY = 6'd1;
    localparam logic [tup_pkg::BASE_W-1:0] BASE_BIN   = 6'd2;
    localparam logic [tup_pkg::BASE_W-1:0] BASE_ALNUM = 6'd36;
    localparam logic [tup_pkg::BASE_W-1:0] BASE_TOP   = 6'd63;

    typedef logic [7:0] t_text[$];

    // One entry of the feed: a character beat or a radix write
    typedef struct {
        bit                         is_radix;
        logic [7:0]                 ch;
        logic                       last;
        logic [tup_pkg::BASE_W-1:0] radix;
    } t_feed_beat;

    typedef struct packed {
        logic [31:0]      value;
        logic             overflowed;
        logic             digits_found;
        logic [END_W-1:0] end_offset;
    } t_conv_result;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} t_rx_mode;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tup_cfg_if cfg_bus ();
    tup_in_if  char_bus ();
    tup_out_if result_bus ();

    text_to_unsigned_parser_unit dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_cfg    (cfg_bus),
        .i_char   (char_bus),
        .o_result (result_bus)
    );

    // Clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    t_feed_beat   feed_q[$];
    t_conv_result conv_expect_q[$];
    int unsigned  fault_count = 0;

    // ------------------------------------------------------------------------
    // Conversion model
    // ------------------------------------------------------------------------
    logic [tup_pkg::BASE_W-1:0] radix_reg;
    tup_pkg::t_phase            scan_phase;
    logic [31:0]                accum;
    logic                       negate;
    tup_pkg::t_status           status;
    logic [tup_pkg::BASE_W-1:0] live_base;
    int unsigned                char_pos;
    int unsigned                stop_pos;

    function automatic void clear_scan();
        scan_phase = tup_pkg::PH_SPACE;
        accum      = '0;
        negate     = 1'b0;
        status     = tup_pkg::ST_NONE;
        live_base  = tup_pkg::BASE_AUTO;
        char_pos   = 0;
        stop_pos   = 0;
    endfunction

    // Value of a letter or digit, NOT_ALNUM for anything else
    function automatic int unsigned char_weight(input logic [7:0] c);
        if (c >= tup_pkg::CH_ZERO && c <= tup_pkg::CH_NINE) begin
            return c - tup_pkg::CH_ZERO;
        end
        if (c >= tup_pkg::CH_UPPER_A && c <= tup_pkg::CH_UPPER_Z) begin
            return c - tup_pkg::CH_UPPER_A + 10;
        end
        if (c >= tup_pkg::CH_LOWER_A && c <= tup_pkg::CH_LOWER_Z) begin
            return c - tup_pkg::CH_LOWER_A + 10;
        end
        return NOT_ALNUM;
    endfunction

    // Fold one digit in, or stop the number at this character
    function automatic void absorb_digit(input logic [7:0] c);
        int unsigned     base_now;
        int unsigned     weight;
        longint unsigned grown;
        base_now = (live_base != 0) ? live_base : tup_pkg::BASE_DEC;
        weight   = char_weight(c);
        if (weight >= base_now) begin
            scan_phase = tup_pkg::PH_DONE;
            stop_pos   = char_pos;
            return;
        end
        grown = accum;
        grown = grown * base_now + weight;
        if (status == tup_pkg::ST_OVF || grown > VALUE_MAX) begin
            status = tup_pkg::ST_OVF;
        end else begin
            status = tup_pkg::ST_DIGITS;
            accum  = grown[31:0];
        end
    endfunction

    // First character after whitespace and sign
    function automatic void start_number(input logic [7:0] c);
        if (c == tup_pkg::CH_ZERO &&
            (radix_reg == tup_pkg::BASE_AUTO || radix_reg == tup_pkg::BASE_HEX)) begin
            scan_phase = tup_pkg::PH_ZERO;
        end else begin
            live_base  = (radix_reg != tup_pkg::BASE_AUTO) ? radix_reg : tup_pkg::BASE_DEC;
            scan_phase = tup_pkg::PH_DIGITS;
            absorb_digit(c);
        end
    endfunction

    // A leading zero not followed by x: octal in auto mode, hex otherwise
    function automatic void resolve_zero();
        live_base  = (radix_reg == tup_pkg::BASE_AUTO) ? tup_pkg::BASE_OCT
                                                       : tup_pkg::BASE_HEX;
        scan_phase = tup_pkg::PH_DIGITS;
        absorb_digit(tup_pkg::CH_ZERO);
    endfunction

    function automatic void advance_pos();
        if (char_pos < tup_pkg::TUP_MAX_LEN) begin
            char_pos++;
        end
    endfunction

    // Take one character beat; returns 1 with the result on the last one
    function automatic bit parse_char(input logic [7:0] c, input logic is_last,
                                      output t_conv_result res);
        int unsigned stop_at;
        res = '0;
        case (scan_phase)
            tup_pkg::PH_SPACE: begin
                if (!(c == tup_pkg::CH_SPACE ||
                      (c >= tup_pkg::CH_TAB && c <= tup_pkg::CH_CR))) begin
                    if (c == tup_pkg::CH_MINUS) begin
                        negate     = 1'b1;
                        scan_phase = tup_pkg::PH_SIGNED;
                    end else if (c == tup_pkg::CH_PLUS) begin
                        scan_phase = tup_pkg::PH_SIGNED;
                    end else begin
                        start_number(c);
                    end
                end
            end
            tup_pkg::PH_SIGNED: begin
                start_number(c);
            end
            tup_pkg::PH_ZERO: begin
                if (c == tup_pkg::CH_LOWER_X || c == tup_pkg::CH_UPPER_X) begin
                    live_base  = tup_pkg::BASE_HEX;
                    scan_phase = tup_pkg::PH_DIGITS;
                end else begin
                    resolve_zero();
                    absorb_digit(c);
                end
            end
            tup_pkg::PH_DIGITS: begin
                absorb_digit(c);
            end
            default: begin
            end
        endcase
        advance_pos();
        if (!is_last) begin
            return 1'b0;
        end
        // a lone zero closing the string still counts as a digit
        if (scan_phase == tup_pkg::PH_ZERO) begin
            resolve_zero();
        end
        stop_at = (scan_phase == tup_pkg::PH_DONE) ? stop_pos : char_pos;
        if (stop_at > tup_pkg::TUP_MAX_LEN) begin
            stop_at = tup_pkg::TUP_MAX_LEN;
        end
        if (status == tup_pkg::ST_NONE) begin
            stop_at = 0;
        end
        if (status == tup_pkg::ST_OVF) begin
            res.value = OVF_CLAMP;
        end else if (negate) begin
            res.value = 32'd0 - accum;
        end else begin
            res.value = accum;
        end
        res.overflowed   = (status == tup_pkg::ST_OVF);
        res.digits_found = (status != tup_pkg::ST_NONE);
        res.end_offset   = stop_at[END_W-1:0];
        clear_scan();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    function automatic void push_bytes(input t_text txt);
        t_feed_beat beat;
        foreach (txt[i]) begin
            beat.is_radix = 1'b0;
            beat.ch       = txt[i];
            beat.last     = (i == txt.size() - 1);
            beat.radix    = '0;
            feed_q.push_back(beat);
        end
    endfunction

    function automatic void push_text(input string s);
        t_text txt;
        txt = {};
        for (int i = 0; i < s.len(); i++) begin
            txt.push_back(s[i]);
        end
        push_bytes(txt);
    endfunction

    function automatic void set_radix(input logic [tup_pkg::BASE_W-1:0] base);
        t_feed_beat beat;
        beat.is_radix = 1'b1;
        beat.ch       = '0;
        beat.last     = 1'b0;
        beat.radix    = base;
        feed_q.push_back(beat);
    endfunction

    // Well formed number: blanks, sign, prefix, digits below the radix, tail
    function automatic t_text make_number(input logic [tup_pkg::BASE_W-1:0] base);
        t_text       txt;
        int unsigned span;
        int unsigned count;
        int unsigned v;
        bit          no_lead_zero;
        txt          = {};
        no_lead_zero = 1'b0;
        if ($urandom_range(0, 9) >= 6) begin
            repeat ($urandom_range(1, 3)) begin
                v = $urandom_range(0, 6);
                txt.push_back((v == 0) ? tup_pkg::CH_SPACE : 8'(tup_pkg::CH_TAB + v - 1));
            end
        end
        v = $urandom_range(0, 3);
        if (v == 0) begin
            txt.push_back(tup_pkg::CH_MINUS);
        end else if (v == 1) begin
            txt.push_back(tup_pkg::CH_PLUS);
        end
        span = (base > BASE_ALNUM) ? BASE_ALNUM : base;
        if (base == tup_pkg::BASE_AUTO || base == tup_pkg::BASE_HEX) begin
            v = $urandom_range(0, 2);
            if (v == 0) begin
                txt.push_back(tup_pkg::CH_ZERO);
                txt.push_back($urandom_range(0, 1) ? tup_pkg::CH_UPPER_X
                                                   : tup_pkg::CH_LOWER_X);
                span = tup_pkg::BASE_HEX;
            end else if (base == tup_pkg::BASE_AUTO && v == 1) begin
                txt.push_back(tup_pkg::CH_ZERO);
                span = tup_pkg::BASE_OCT;
            end else if (base == tup_pkg::BASE_AUTO) begin
                span         = tup_pkg::BASE_DEC;
                no_lead_zero = 1'b1;
            end
        end
        v     = $urandom_range(0, 7);
        count = (v == 0) ? 0 : (v < 3) ? $urandom_range(8, 40) : $urandom_range(1, 7);
        for (int i = 0; i < count; i++) begin
            v = (no_lead_zero && i == 0) ? $urandom_range(1, span - 1)
                                         : $urandom_range(0, span - 1);
            if (v < 10) begin
                txt.push_back(8'(tup_pkg::CH_ZERO + v));
            end else begin
                txt.push_back(8'(($urandom_range(0, 1) ? tup_pkg::CH_UPPER_A
                                                       : tup_pkg::CH_LOWER_A) + v - 10));
            end
        end
        if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(0, 255)));
        end
        if (txt.size() == 0) begin
            txt.push_back(8'($urandom_range(0, 255)));
        end
        return txt;
    endfunction

    // Noise and broken sequences
    function automatic t_text make_junk();
        t_text txt;
        txt = {};
        case ($urandom_range(0, 3))
            0: begin
                txt.push_back($urandom_range(0, 1) ? tup_pkg::CH_PLUS : tup_pkg::CH_MINUS);
                txt.push_back($urandom_range(0, 1) ? tup_pkg::CH_PLUS : tup_pkg::CH_MINUS);
                txt.push_back(8'(tup_pkg::CH_ZERO + $urandom_range(0, 9)));
            end
            1: begin
                txt.push_back(tup_pkg::CH_ZERO);
                txt.push_back(tup_pkg::CH_LOWER_X);
                txt.push_back(8'($urandom_range(0, 255)));
            end
            2: begin
                repeat ($urandom_range(1, 4)) begin
                    txt.push_back($urandom_range(0, 1) ? tup_pkg::CH_SPACE : tup_pkg::CH_TAB);
                end
            end
            default: begin
                repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        return txt;
    endfunction

    // Long string that drives the character index into saturation
    function automatic t_text make_padded(input int unsigned pad, input bit stop_early);
        t_text txt;
        txt = {};
        repeat (pad) txt.push_back(tup_pkg::CH_SPACE);
        txt.push_back(tup_pkg::CH_ZERO);
        if (stop_early) begin
            txt.push_back(tup_pkg::CH_MINUS);
            txt.push_back(tup_pkg::CH_NINE);
        end
        return txt;
    endfunction

    // ------------------------------------------------------------------------
    // Character and radix driver: bursts and gaps, radix writes only when idle
    // ------------------------------------------------------------------------
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned quiet_cycles;

    always @(posedge clk) begin : feed_driver
        t_feed_beat head;
        logic       hold;
        logic       char_go;
        logic       cfg_go;
        if (!rst_n) begin
            char_bus.valid <= 1'b0;
            cfg_bus.valid  <= 1'b0;
            burst_left     <= 1;
            gap_left       <= 0;
            quiet_cycles   <= 0;
        end else begin
            // count cycles with nothing in flight
            if (char_bus.valid || cfg_bus.valid || conv_expect_q.size() != 0) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            hold = (char_bus.valid && !char_bus.ready) || (cfg_bus.valid && !cfg_bus.ready);
            if (!hold) begin
                char_go = 1'b0;
                cfg_go  = 1'b0;
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (feed_q.size() != 0) begin
                    head = feed_q[0];
                    if (!head.is_radix) begin
                        char_go       = 1'b1;
                        char_bus.ch   <= head.ch;
                        char_bus.last <= head.last;
                        void'(feed_q.pop_front());
                        if (burst_left <= 1) begin
                            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                                      : $urandom_range(1, 12);
                            gap_left   <= ($urandom_range(0, 3) == 0) ? 0
                                                                      : $urandom_range(1, 7);
                        end else begin
                            burst_left <= burst_left - 1;
                        end
                    end else if (!char_bus.valid && quiet_cycles >= SETTLE_CYCLES) begin
                        // block drained: safe to change the radix
                        cfg_go              = 1'b1;
                        cfg_bus.number_base <= head.radix;
                        void'(feed_q.pop_front());
                    end
                end
                char_bus.valid <= char_go;
                cfg_bus.valid  <= cfg_go;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result back-pressure: modes switch after random spans
    // ------------------------------------------------------------------------
    t_rx_mode    rx_mode;
    int unsigned rx_span;

    always @(posedge clk) begin
        if (!rst_n) begin
            result_bus.ready <= 1'b0;
            rx_mode          <= RX_OPEN;
            rx_span          <= 0;
        end else begin
            if (rx_span == 0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
                rx_span <= $urandom_range(16, 128);
            end else begin
                rx_span <= rx_span - 1;
            end
            case (rx_mode)
                RX_OPEN:   result_bus.ready <= 1'b1;
                RX_COIN:   result_bus.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: result_bus.ready <= ($urandom_range(0, 5) == 0);
                default:   result_bus.ready <= (rx_span[2:0] == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on accepted beats, check result beats in order
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : result_monitor
        t_conv_result want;
        t_conv_result got;
        if (!rst_n) begin
            radix_reg = tup_pkg::BASE_RESET;
            clear_scan();
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                radix_reg = cfg_bus.number_base;
            end
            if (char_bus.valid && char_bus.ready) begin
                if (parse_char(char_bus.ch, char_bus.last, want)) begin
                    conv_expect_q.push_back(want);
                end
            end
            if (result_bus.valid && result_bus.ready) begin
                got.value        = result_bus.value;
                got.overflowed   = result_bus.overflowed;
                got.digits_found = result_bus.digits_found;
                got.end_offset   = result_bus.end_offset;
                if (conv_expect_q.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("ERROR: unexpected result beat value=%h ovf=%b found=%b end=%0d",
                                 got.value, got.overflowed, got.digits_found, got.end_offset);
                    end
                end else begin
                    want = conv_expect_q.pop_front();
                    if (got.value !== want.value || got.overflowed !== want.overflowed ||
                        got.digits_found !== want.digits_found ||
                        got.end_offset !== want.end_offset) begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT) begin
                            $display("ERROR: exp value=%h ovf=%b found=%b end=%0d",
                                     want.value, want.overflowed, want.digits_found,
                                     want.end_offset);
                            $display("       got value=%h ovf=%b found=%b end=%0d",
                                     got.value, got.overflowed, got.digits_found,
                                     got.end_offset);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        t_text                      txt;
        logic [tup_pkg::BASE_W-1:0] base;
        int unsigned                random_chars;
        int unsigned                phase_no;
        int unsigned                phase_len;
        int unsigned                phase_chars;

        char_bus.valid      = 1'b0;
        char_bus.ch         = '0;
        char_bus.last       = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.number_base = tup_pkg::BASE_RESET;
        result_bus.ready    = 1'b0;

        // Directed: radix 10 from reset
        push_text("\t-12z9");
        push_text("4294967296");
        push_text("+-5");
        txt = {8'h00};
        push_bytes(txt);
        txt = {tup_pkg::CH_NINE, 8'hFF};
        push_bytes(txt);
        // auto radix: lone zero, bare prefix, octal, hex
        set_radix(tup_pkg::BASE_AUTO);
        push_text("0");
        push_text(" +0x!");
        push_text("017");
        push_text("-0X1f");
        // only zero is a digit
        set_radix(BASE_UNARY);
        push_text("010");
        // every letter and digit valid
        set_radix(BASE_TOP);
        push_text("zZ9");

        // Random phases, each under its own radix
        random_chars = 0;
        phase_no     = 0;
        while (random_chars < RANDOM_CHARS) begin
            case ($urandom_range(0, 9))
                0:       base = tup_pkg::BASE_AUTO;
                1:       base = tup_pkg::BASE_HEX;
                2:       base = tup_pkg::BASE_DEC;
                3:       base = tup_pkg::BASE_OCT;
                4:       base = BASE_BIN;
                5:       base = BASE_ALNUM;
                6:       base = BASE_UNARY;
                7:       base = BASE_TOP;
                default: base = 6'($urandom_range(0, 63));
            endcase
            set_radix(base);
            if (phase_no == 0) begin
                // one string long enough to saturate the character index
                push_bytes(make_padded(tup_pkg::TUP_MAX_LEN + 4, 1'($urandom_range(0, 1))));
            end
            phase_len   = $urandom_range(16, 48);
            phase_chars = 0;
            while (phase_chars < phase_len) begin
                if ($urandom_range(0, 19) < 16) begin
                    txt = make_number(base);
                end else begin
                    txt = make_junk();
                end
                push_bytes(txt);
                phase_chars += txt.size();
            end
            random_chars += phase_chars;
            phase_no++;
        end
        // back to the reset radix at the end
        set_radix(tup_pkg::BASE_RESET);
        push_text(" 7");

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || char_bus.valid || cfg_bus.valid ||
               conv_expect_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES * 4) @(posedge clk);

        if (fault_count == 0 && conv_expect_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/tup_pkg.sv
hw/rtl/tup_if.sv
hw/rtl/tup_step.sv
hw/rtl/text_to_unsigned_parser_unit.sv
tb/tb_text_to_unsigned_parser_unit.sv
